[src/dsp_pkg.sv]
`default_nettype none

package dsp_pkg;

	// Default build-time sizes.
	localparam int DSP_NUM_POSITIONS = 4;
	localparam int DSP_SAMPLE_BITS   = 10;

	// Fixed field widths.
	localparam int THR_W      = 10;
	localparam int STEP_W     = 7;
	localparam int SERVO_W    = 8;
	localparam int TICK_W     = 16;
	localparam int MODE_W     = 2;
	localparam int TGT_W      = 2;
	localparam int POS_OUT_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Largest servo command.
	localparam logic [SERVO_W-1:0] SERVO_MAX = 8'd180;

	// Command codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_MOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_NEG = 3'd5;

	// Configuration reset values.
	localparam logic [THR_W-1:0]   RST_LOWER    = 10'd100;
	localparam logic [THR_W-1:0]   RST_UPPER    = 10'd250;
	localparam logic [STEP_W-1:0]  RST_STEP     = 7'd5;
	localparam logic [SERVO_W-1:0] RST_STOP     = 8'd92;
	localparam logic [TICK_W-1:0]  RST_TIMEOUT  = 16'd100;
	localparam logic               RST_ZERO_NEG = 1'b1;

	typedef struct packed {
		logic [THR_W-1:0]   lower_threshold;
		logic [THR_W-1:0]   upper_threshold;
		logic [STEP_W-1:0]  rotation_step;
		logic [SERVO_W-1:0] stop_value;
		logic [TICK_W-1:0]  timeout_ticks;
		logic               zero_turn_negative;
	} dsp_cfg_t;

	typedef struct packed {
		logic [SERVO_W-1:0]          servo_value;
		logic                        servo_attached;
		logic                        busy_res;
		logic                        done_res;
		logic                        no_timeout;
		logic signed [POS_OUT_W-1:0] position;
	} dsp_result_t;

endpackage

`default_nettype wire

[src/dsp_ctrl.sv]
`default_nettype none

module dsp_ctrl
	import dsp_pkg::*;
#(
	parameter int NUM_POSITIONS = DSP_NUM_POSITIONS,
	parameter int SAMPLE_BITS   = DSP_SAMPLE_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic [MODE_W-1:0]      mode,
	input  wire logic [TGT_W-1:0]       target_position,
	input  wire logic [SAMPLE_BITS-1:0] sensor_sample,
	input  wire dsp_cfg_t               cfg,
	output dsp_result_t                 result_q
);

	localparam int POS_W = $clog2(NUM_POSITIONS + 1) + 1;
	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
	localparam int SUM_W = SERVO_W + 2;
	localparam logic signed [POS_W-1:0] POS_UNKNOWN = POS_W'(-1);
	localparam logic signed [POS_W-1:0] POS_PAST_END = POS_W'(NUM_POSITIONS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_PLAN,
		ST_FALL,
		ST_RISE
	} state_t;

	state_t                   state_q;
	logic signed [POS_W-1:0]  cur_pos_q;
	logic                     dir_q;
	logic [TICK_W-1:0]        elapsed_q;
	logic [TGT_W-1:0]         goal_q;
	logic [TGT_W-1:0]         final_q;
	logic                     pending_rst_q;
	logic [1:0]               recovery_q;
	logic                     flag_q;
	logic                     drive_q;

	state_t                   n_state;
	logic signed [POS_W-1:0]  n_cur_pos;
	logic                     n_dir;
	logic [TICK_W-1:0]        n_elapsed;
	logic [TGT_W-1:0]         n_goal;
	logic [TGT_W-1:0]         n_final;
	logic                     n_pending_rst;
	logic [1:0]               n_recovery;
	logic                     n_flag;
	logic                     n_drive;
	logic                     n_done;
	dsp_result_t              n_result;

	logic [TGT_W-1:0]         tgt;
	logic [CMP_W-1:0]         sample_x;
	logic                     below_lower;
	logic                     above_upper;
	logic                     tick_expired;
	logic [TICK_W-1:0]        elapsed_inc;
	logic signed [POS_W-1:0]  goal_x;
	logic                     do_zero_done;
	logic                     zero_ok;
	logic                     do_finish;
	logic                     finish_flag;
	logic                     turn_neg;
	logic                     turning;
	logic signed [SUM_W-1:0]  servo_sum;
	logic [POS_W+POS_OUT_W-1:0] pos_ext;

	// Target detent folded into range; at most one subtraction is needed.
	assign tgt = (int'(target_position) >= NUM_POSITIONS)
		? TGT_W'(int'(target_position) - NUM_POSITIONS) : target_position;

	// Sensor compares and the step timer.
	assign sample_x     = CMP_W'(sensor_sample);
	assign below_lower  = sample_x < CMP_W'(cfg.lower_threshold);
	assign above_upper  = sample_x > CMP_W'(cfg.upper_threshold);
	assign tick_expired = ({1'b0, elapsed_q} + 17'd1) >= {1'b0, cfg.timeout_ticks};
	assign elapsed_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);
	assign goal_x       = POS_W'(goal_q);

	// Next-state logic for one tick.
	always_comb begin
		n_state       = state_q;
		n_cur_pos     = cur_pos_q;
		n_dir         = dir_q;
		n_elapsed     = elapsed_q;
		n_goal        = goal_q;
		n_final       = final_q;
		n_pending_rst = pending_rst_q;
		n_recovery    = recovery_q;
		n_flag        = flag_q;
		n_drive       = drive_q;
		n_done        = 1'b0;
		do_zero_done  = 1'b0;
		zero_ok       = 1'b0;
		do_finish     = 1'b0;
		finish_flag   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (mode == MODE_MOVE || mode == MODE_ZERO) begin
					n_pending_rst = (mode == MODE_ZERO);
					n_final       = tgt;
					n_recovery    = 2'd0;
					n_flag        = 1'b1;
					n_drive       = 1'b1;
					n_elapsed     = '0;
					if (cur_pos_q == POS_UNKNOWN) begin
						n_state = ST_ZERO;
					end else if (mode == MODE_ZERO) begin
						n_cur_pos   = '0;
						do_finish   = 1'b1;
						finish_flag = 1'b1;
					end else begin
						n_goal  = tgt;
						n_state = ST_PLAN;
					end
				end
			end
			ST_ZERO: begin
				if (above_upper) begin
					do_zero_done = 1'b1;
					zero_ok      = 1'b1;
				end else if (tick_expired) begin
					// Zeroing failed: assume detent 0 and verify by moving to detent 1.
					n_cur_pos  = '0;
					n_recovery = 2'd1;
					n_goal     = TGT_W'(1);
					n_flag     = 1'b1;
					n_state    = ST_PLAN;
				end else begin
					n_elapsed = elapsed_inc;
				end
			end
			ST_PLAN: begin
				if (cur_pos_q != goal_x) begin
					n_dir     = goal_x > cur_pos_q;
					n_elapsed = '0;
					n_state   = ST_FALL;
				end else if (recovery_q == 2'd1) begin
					if (flag_q) begin
						do_zero_done = 1'b1;
					end else begin
						n_recovery = 2'd2;
						n_goal     = '0;
						n_flag     = 1'b1;
					end
				end else if (recovery_q == 2'd2) begin
					do_zero_done = 1'b1;
				end else begin
					do_finish   = 1'b1;
					finish_flag = flag_q;
				end
			end
			ST_FALL: begin
				if (below_lower) begin
					n_elapsed = elapsed_inc;
					n_state   = ST_RISE;
				end else if (tick_expired) begin
					n_flag    = 1'b0;
					n_cur_pos = dir_q ? POS_PAST_END : POS_UNKNOWN;
					n_state   = ST_PLAN;
				end else begin
					n_elapsed = elapsed_inc;
				end
			end
			ST_RISE: begin
				if (above_upper) begin
					n_cur_pos = dir_q ? cur_pos_q + POS_W'(1) : cur_pos_q - POS_W'(1);
					n_state   = ST_PLAN;
				end else if (tick_expired) begin
					n_flag    = 1'b0;
					n_cur_pos = dir_q ? POS_PAST_END : POS_UNKNOWN;
					n_state   = ST_PLAN;
				end else begin
					n_elapsed = elapsed_inc;
				end
			end
			default: begin
				n_state = ST_IDLE;
			end
		endcase

		// Zeroing is over: either report the reset or go on with the move.
		if (do_zero_done) begin
			n_cur_pos  = '0;
			n_recovery = 2'd0;
			if (pending_rst_q) begin
				do_finish   = 1'b1;
				finish_flag = zero_ok;
			end else begin
				n_goal  = final_q;
				n_flag  = 1'b1;
				n_state = ST_PLAN;
			end
		end

		// Command complete.
		if (do_finish) begin
			n_state    = ST_IDLE;
			n_drive    = 1'b0;
			n_recovery = 2'd0;
			n_flag     = finish_flag;
			n_done     = 1'b1;
		end
	end

	// Servo command from the state after this tick, clamped to the servo range.
	assign turning  = (n_state == ST_ZERO) || (n_state == ST_FALL) || (n_state == ST_RISE);
	assign turn_neg = (n_state == ST_ZERO) ? cfg.zero_turn_negative : !n_dir;

	always_comb begin
		servo_sum = $signed({2'b00, cfg.stop_value});
		if (turning) begin
			if (turn_neg) begin
				servo_sum = servo_sum - $signed({3'b000, cfg.rotation_step});
			end else begin
				servo_sum = servo_sum + $signed({3'b000, cfg.rotation_step});
			end
		end
	end

	assign pos_ext = {{POS_OUT_W{n_cur_pos[POS_W-1]}}, n_cur_pos};

	always_comb begin
		if (servo_sum < 0) begin
			n_result.servo_value = '0;
		end else if (servo_sum > $signed({2'b00, SERVO_MAX})) begin
			n_result.servo_value = SERVO_MAX;
		end else begin
			n_result.servo_value = servo_sum[SERVO_W-1:0];
		end
		n_result.servo_attached = n_drive;
		n_result.busy_res       = (n_state != ST_IDLE);
		n_result.done_res       = n_done;
		n_result.no_timeout     = n_done & n_flag;
		n_result.position       = $signed(pos_ext[POS_OUT_W-1:0]);
	end

	// State and result register, advanced once per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cur_pos_q     <= POS_UNKNOWN;
			dir_q         <= 1'b0;
			elapsed_q     <= '0;
			goal_q        <= '0;
			final_q       <= '0;
			pending_rst_q <= 1'b0;
			recovery_q    <= 2'd0;
			flag_q        <= 1'b1;
			drive_q       <= 1'b0;
			result_q      <= '0;
		end else if (advance) begin
			state_q       <= n_state;
			cur_pos_q     <= n_cur_pos;
			dir_q         <= n_dir;
			elapsed_q     <= n_elapsed;
			goal_q        <= n_goal;
			final_q       <= n_final;
			pending_rst_q <= n_pending_rst;
			recovery_q    <= n_recovery;
			flag_q        <= n_flag;
			drive_q       <= n_drive;
			result_q      <= n_result;
		end
	end

	// The controller only moves on a transfer.
	a_hold_without_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without an input transfer");

	// A finished command is never reported as still running.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_q.done_res |-> !result_q.busy_res)
		else $error("done reported together with busy");

	// Any active command keeps the servo drive enabled.
	a_busy_drives: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> drive_q)
		else $error("command in progress with drive disabled");

	// Reaching the upper threshold ends a step and replans.
	a_rise_ends_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q == ST_RISE && above_upper |=> state_q == ST_PLAN)
		else $error("step did not end on a detent crossing");

endmodule

`default_nettype wire

[src/detent_servo_positioner_core.sv]
// Detent servo positioner.
// Input channel (in_valid/in_stall): one sample tick per transfer, carrying mode
// (plain tick, move to target_position, or reset to zero) and sensor_sample.
// Output channel (out_valid/out_stall): exactly one result per input transfer,
// carrying the servo command, drive enable, busy, a done pulse with its
// no_timeout status, and the tracked detent position (-1 when unknown).
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high; a
// transfer writes cfg_data into register cfg_index. Indexes past the last
// register are ignored. Write only while no result is outstanding.
// The result of a tick is loaded into the output register at its transfer edge
// and can be taken from the next edge on. One tick is taken every cycle unless
// a waiting result is stalled; the state update of the controller is a single
// pass of compare logic per tick.
// When the receiver stalls with a result waiting, in_stall rises in the same
// cycle and the held result stays unchanged until it is taken.
// Reset clears the output register, returns the controller to idle with the
// position unknown, and loads the default configuration.
`default_nettype none

module detent_servo_positioner_core
	import dsp_pkg::*;
#(
	parameter int NUM_POSITIONS = DSP_NUM_POSITIONS,
	parameter int SAMPLE_BITS   = DSP_SAMPLE_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [MODE_W-1:0]           mode,
	input  wire logic [TGT_W-1:0]            target_position,
	input  wire logic [SAMPLE_BITS-1:0]      sensor_sample,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [SERVO_W-1:0]               servo_value,
	output logic                             servo_attached,
	output logic                             busy_res,
	output logic                             done_res,
	output logic                             no_timeout,
	output logic signed [POS_OUT_W-1:0]      position,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

	dsp_cfg_t    cfg_q;
	dsp_result_t result_q;
	logic        out_valid_q;
	logic        in_xfer;

	// Input is held back only while a result waits on a stalled receiver.
	assign in_stall  = out_valid_q & out_stall;
	assign in_xfer   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_threshold    <= RST_LOWER;
			cfg_q.upper_threshold    <= RST_UPPER;
			cfg_q.rotation_step      <= RST_STEP;
			cfg_q.stop_value         <= RST_STOP;
			cfg_q.timeout_ticks      <= RST_TIMEOUT;
			cfg_q.zero_turn_negative <= RST_ZERO_NEG;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOWER:    cfg_q.lower_threshold    <= cfg_data[THR_W-1:0];
				CFG_UPPER:    cfg_q.upper_threshold    <= cfg_data[THR_W-1:0];
				CFG_STEP:     cfg_q.rotation_step      <= cfg_data[STEP_W-1:0];
				CFG_STOP:     cfg_q.stop_value         <= cfg_data[SERVO_W-1:0];
				CFG_TIMEOUT:  cfg_q.timeout_ticks      <= cfg_data[TICK_W-1:0];
				CFG_ZERO_NEG: cfg_q.zero_turn_negative <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	dsp_ctrl #(
		.NUM_POSITIONS (NUM_POSITIONS),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (in_xfer),
		.mode            (mode),
		.target_position (target_position),
		.sensor_sample   (sensor_sample),
		.cfg             (cfg_q),
		.result_q        (result_q)
	);

	// Output valid: set by an input transfer, cleared once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign servo_value    = result_q.servo_value;
	assign servo_attached = result_q.servo_attached;
	assign busy_res       = result_q.busy_res;
	assign done_res       = result_q.done_res;
	assign no_timeout     = result_q.no_timeout;
	assign position       = result_q.position;

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsp_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int NPOS        = DSP_NUM_POSITIONS;
	localparam int SMP_W       = DSP_SAMPLE_BITS;
	localparam int SMP_MAX     = (1 << SMP_W) - 1;
	localparam int TICK_SAT    = 'hFFFF;
	localparam int IDLE_PCT    = 29;

	// Mode codes that the package leaves unnamed, and a register index past the last one.
	localparam logic [MODE_W-1:0]    MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

	// Sensor levels relative to the two thresholds.
	typedef enum int {LVL_LOW, LVL_MID, LVL_HIGH} level_t;

	// Controller phases of the positioner.
	typedef enum logic [2:0] {CTL_IDLE, CTL_ZERO, CTL_PLAN, CTL_FALL, CTL_RISE} ctl_state_t;

	typedef struct {
		bit                   hold;
		logic [MODE_W-1:0]    md;
		logic [TGT_W-1:0]     tgt;
		logic [SMP_W-1:0]     smp;
	} tick_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [MODE_W-1:0]         mode = '0;
	logic [TGT_W-1:0]          target_position = '0;
	logic [SMP_W-1:0]          sensor_sample = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [SERVO_W-1:0]        servo_value;
	logic                      servo_attached;
	logic                      busy_res;
	logic                      done_res;
	logic                      no_timeout;
	logic signed [POS_OUT_W-1:0] position;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	detent_servo_positioner_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.target_position(target_position),
		.sensor_sample(sensor_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.servo_value(servo_value),
		.servo_attached(servo_attached),
		.busy_res(busy_res),
		.done_res(done_res),
		.no_timeout(no_timeout),
		.position(position),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tick_t       pending_ticks[$];
	dsp_result_t expected_results[$];
	bit          in_took = 1'b0;
	bit          steady = 1'b0;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          ticks_taken = 0;
	int          settings_used = 0;
	int          cmds_done = 0;
	int          cmds_timed_out = 0;

	// Positioner state as the checker tracks it.
	dsp_cfg_t      servo_cfg;
	ctl_state_t    ctl;
	int            det_pos;
	bit            dir_up;
	int            elapsed;
	logic [TGT_W-1:0] goal;
	logic [TGT_W-1:0] final_goal;
	bit            zero_pending;
	int            rec_stage;
	bit            clean_run;
	bit            drive_on;
	bit            done_now;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void reset_positioner();
		servo_cfg.lower_threshold    = RST_LOWER;
		servo_cfg.upper_threshold    = RST_UPPER;
		servo_cfg.rotation_step      = RST_STEP;
		servo_cfg.stop_value         = RST_STOP;
		servo_cfg.timeout_ticks      = RST_TIMEOUT;
		servo_cfg.zero_turn_negative = RST_ZERO_NEG;
		ctl          = CTL_IDLE;
		det_pos      = -1;
		dir_up       = 1'b0;
		elapsed      = 0;
		goal         = '0;
		final_goal   = '0;
		zero_pending = 1'b0;
		rec_stage    = 0;
		clean_run    = 1'b1;
		drive_on     = 1'b0;
	endfunction

	// A tick that misses its condition either expires the step or counts up.
	function automatic bit step_expired();
		if (elapsed + 1 >= int'(servo_cfg.timeout_ticks))
			return 1'b1;
		if (elapsed < TICK_SAT)
			elapsed++;
		return 1'b0;
	endfunction

	function automatic void close_command(bit ok);
		ctl       = CTL_IDLE;
		drive_on  = 1'b0;
		rec_stage = 0;
		clean_run = ok;
		done_now  = 1'b1;
	endfunction

	// Zeroing has settled; a pending move goes on from detent zero.
	function automatic void zero_found(bit ok);
		det_pos   = 0;
		rec_stage = 0;
		if (zero_pending) begin
			close_command(ok);
		end else begin
			goal      = final_goal;
			clean_run = 1'b1;
			ctl       = CTL_PLAN;
		end
	endfunction

	// A lost step parks the position one past the end it was heading for.
	function automatic void step_lost();
		clean_run = 1'b0;
		det_pos   = dir_up ? NPOS : -1;
		ctl       = CTL_PLAN;
	endfunction

	function automatic dsp_result_t predict_tick(logic [MODE_W-1:0] md, logic [TGT_W-1:0] tgt,
			logic [SMP_W-1:0] smp);
		dsp_result_t r;
		int servo;
		int step_amt;
		done_now = 1'b0;
		case (ctl)
			CTL_IDLE: begin
				if (md == MODE_MOVE || md == MODE_ZERO) begin
					zero_pending = (md == MODE_ZERO);
					final_goal   = TGT_W'(int'(tgt) % NPOS);
					rec_stage    = 0;
					clean_run    = 1'b1;
					drive_on     = 1'b1;
					elapsed      = 0;
					if (det_pos == -1) begin
						ctl = CTL_ZERO;
					end else if (md == MODE_ZERO) begin
						det_pos = 0;
						close_command(1'b1);
					end else begin
						goal = final_goal;
						ctl  = CTL_PLAN;
					end
				end
			end
			CTL_ZERO: begin
				if (smp > servo_cfg.upper_threshold) begin
					zero_found(1'b1);
				end else if (step_expired()) begin
					det_pos   = 0;
					rec_stage = 1;
					goal      = 1;
					clean_run = 1'b1;
					ctl       = CTL_PLAN;
				end
			end
			CTL_PLAN: begin
				if (det_pos != int'(goal)) begin
					dir_up  = int'(goal) > det_pos;
					elapsed = 0;
					ctl     = CTL_FALL;
				end else if (rec_stage == 1) begin
					// The recovery move decides whether detent zero can be trusted.
					if (clean_run) begin
						zero_found(1'b0);
					end else begin
						rec_stage = 2;
						goal      = 0;
						clean_run = 1'b1;
					end
				end else if (rec_stage == 2) begin
					zero_found(1'b0);
				end else begin
					close_command(clean_run);
				end
			end
			CTL_FALL: begin
				if (smp < servo_cfg.lower_threshold) begin
					if (elapsed < TICK_SAT)
						elapsed++;
					ctl = CTL_RISE;
				end else if (step_expired()) begin
					step_lost();
				end
			end
			CTL_RISE: begin
				if (smp > servo_cfg.upper_threshold) begin
					det_pos += dir_up ? 1 : -1;
					ctl = CTL_PLAN;
				end else if (step_expired()) begin
					step_lost();
				end
			end
			default: ctl = CTL_IDLE;
		endcase

		// Servo command: stop value offset by the turn, clamped to the servo range.
		servo    = servo_cfg.stop_value;
		step_amt = servo_cfg.rotation_step;
		if (ctl == CTL_ZERO)
			servo += servo_cfg.zero_turn_negative ? -step_amt : step_amt;
		else if (ctl == CTL_FALL || ctl == CTL_RISE)
			servo += dir_up ? step_amt : -step_amt;
		if (servo < 0)
			servo = 0;
		if (servo > int'(SERVO_MAX))
			servo = SERVO_MAX;

		r.servo_value    = servo[SERVO_W-1:0];
		r.servo_attached = drive_on;
		r.busy_res       = (ctl != CTL_IDLE);
		r.done_res       = done_now;
		r.no_timeout     = done_now & clean_run;
		r.position       = det_pos[POS_OUT_W-1:0];
		return r;
	endfunction

	// Ticks go out on the falling edge; a stalled tick is held as it is.
	always @(negedge clk) begin : drive_ticks
		tick_t head;
		bit offer;
		if (arst_n && (!in_valid || in_took)) begin
			while (pending_ticks.size() > 0 && pending_ticks[0].hold && expected_results.size() == 0)
				void'(pending_ticks.pop_front());
			offer = pending_ticks.size() > 0 && !pending_ticks[0].hold
				&& !(!steady && $urandom_range(0, 99) < IDLE_PCT);
			if (offer) begin
				head = pending_ticks.pop_front();
				mode            <= head.md;
				target_position <= head.tgt;
				sensor_sample   <= head.smp;
			end
			in_valid <= offer;
		end
		out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Results are checked against the oldest prediction before the new tick is predicted.
	always @(posedge clk) begin : check_results
		dsp_result_t want;
		dsp_result_t next_res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no tick outstanding");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (servo_value !== want.servo_value) begin
						$error("servo_value: expected %0d, got %0d", want.servo_value, servo_value);
						mismatches++;
					end
					if (servo_attached !== want.servo_attached) begin
						$error("servo_attached: expected %0d, got %0d", want.servo_attached,
							servo_attached);
						mismatches++;
					end
					if (busy_res !== want.busy_res) begin
						$error("busy_res: expected %0d, got %0d", want.busy_res, busy_res);
						mismatches++;
					end
					if (done_res !== want.done_res) begin
						$error("done_res: expected %0d, got %0d", want.done_res, done_res);
						mismatches++;
					end
					if (no_timeout !== want.no_timeout) begin
						$error("no_timeout: expected %0d, got %0d", want.no_timeout, no_timeout);
						mismatches++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, position);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				next_res = predict_tick(mode, target_position, sensor_sample);
				expected_results.push_back(next_res);
				ticks_taken++;
				if (next_res.done_res) begin
					cmds_done++;
					if (!next_res.no_timeout)
						cmds_timed_out++;
				end
			end
		end
		in_took <= in_valid && !in_stall;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LOWER:    servo_cfg.lower_threshold    = THR_W'(val);
			CFG_UPPER:    servo_cfg.upper_threshold    = THR_W'(val);
			CFG_STEP:     servo_cfg.rotation_step      = STEP_W'(val);
			CFG_STOP:     servo_cfg.stop_value         = SERVO_W'(val);
			CFG_TIMEOUT:  servo_cfg.timeout_ticks      = TICK_W'(val);
			CFG_ZERO_NEG: servo_cfg.zero_turn_negative = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input int lower, input int upper, input int step, input int stop,
			input int ticks, input int zero_neg);
		write_reg(CFG_LOWER, lower);
		write_reg(CFG_UPPER, upper);
		write_reg(CFG_STEP, step);
		write_reg(CFG_STOP, stop);
		write_reg(CFG_TIMEOUT, ticks);
		write_reg(CFG_ZERO_NEG, zero_neg);
		settings_used++;
	endtask

	task automatic add_tick(input logic [MODE_W-1:0] md, input int tgt, input int smp);
		tick_t t;
		t.hold = 1'b0;
		t.md   = md;
		t.tgt  = TGT_W'(tgt);
		t.smp  = SMP_W'(smp);
		pending_ticks.push_back(t);
	endtask

	task automatic add_hold();
		tick_t t;
		t = '{hold: 1'b1, md: MODE_TICK, tgt: '0, smp: '0};
		pending_ticks.push_back(t);
	endtask

	// A sample below, between or above the current thresholds, where such a value exists.
	function automatic int level_sample(level_t lvl);
		int lo;
		int hi;
		lo = servo_cfg.lower_threshold;
		hi = servo_cfg.upper_threshold;
		case (lvl)
			LVL_LOW:  return (lo == 0) ? 0 : $urandom_range(0, lo - 1);
			LVL_HIGH: return (hi >= SMP_MAX) ? SMP_MAX : $urandom_range(hi + 1, SMP_MAX);
			default:  return $urandom_range(lo, hi);
		endcase
	endfunction

	// Mostly commands followed by a detent wave, with noise bursts and one drain pause.
	task automatic fill_random(input int n);
		int made;
		int run;
		int left;
		int hold_at;
		bit held;
		bit lvl_high;
		logic [MODE_W-1:0] md;
		int smp;
		made    = 0;
		held    = 1'b0;
		hold_at = $urandom_range(n / 4, 3 * n / 4);
		while (made < n) begin
			if (!held && made >= hold_at) begin
				add_hold();
				held = 1'b1;
			end
			if ($urandom_range(0, 99) < 80) begin
				md = ($urandom_range(0, 9) == 0) ? MODE_ZERO : MODE_MOVE;
				add_tick(md, $urandom_range(0, 3), $urandom_range(0, SMP_MAX));
				run      = $urandom_range(8, 40);
				lvl_high = $urandom_range(0, 1);
				left     = $urandom_range(1, 6);
				repeat (run) begin
					md = MODE_TICK;
					if ($urandom_range(0, 19) == 0)
						md = MODE_W'($urandom_range(0, 3));
					if ($urandom_range(0, 9) == 0)
						smp = $urandom_range(0, SMP_MAX);
					else if ($urandom_range(0, 99) < 15)
						smp = level_sample(LVL_MID);
					else
						smp = level_sample(lvl_high ? LVL_HIGH : LVL_LOW);
					add_tick(md, $urandom_range(0, 3), smp);
					left--;
					if (left == 0) begin
						lvl_high = !lvl_high;
						left     = $urandom_range(1, 7);
					end
				end
				made += run + 1;
			end else begin
				run = $urandom_range(1, 8);
				repeat (run)
					add_tick(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 3),
						$urandom_range(0, SMP_MAX));
				made += run;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		reset_positioner();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zeroing that times out, a recovery move that times out and returns,
		// then an immediate reset, a move and exact threshold values.
		set_config(100, 250, 5, 92, 3, 0);
		add_tick(MODE_TICK, 0, 0);
		add_tick(MODE_SPARE, 3, SMP_MAX);
		add_tick(MODE_ZERO, 0, 512);
		add_tick(MODE_MOVE, 2, 150);
		repeat (3) add_tick(MODE_TICK, 1, 150);
		repeat (3) add_tick(MODE_TICK, 0, SMP_MAX);
		repeat (3) begin
			add_tick(MODE_TICK, 0, 150);
			add_tick(MODE_TICK, 0, 0);
			add_tick(MODE_TICK, 0, SMP_MAX);
		end
		add_tick(MODE_TICK, 0, 150);
		add_tick(MODE_TICK, 0, 150);
		add_tick(MODE_TICK, 0, 0);
		add_tick(MODE_TICK, 0, SMP_MAX);
		add_tick(MODE_TICK, 0, 150);
		add_tick(MODE_ZERO, 1, 600);
		add_tick(MODE_MOVE, 3, 300);
		add_tick(MODE_TICK, 0, 300);
		add_tick(MODE_TICK, 0, 100);
		add_tick(MODE_TICK, 0, 99);
		add_tick(MODE_TICK, 0, 250);
		add_tick(MODE_TICK, 0, 251);
		wait_drained();

		// Random phases under several register settings, the extremes among them.
		set_config(100, 250, 5, 92, 100, 1);
		fill_random(180);
		wait_drained();

		steady = 1'b1;
		set_config(300, 700, 90, 180, 6, 0);
		fill_random(180);
		wait_drained();
		steady = 1'b0;

		set_config(0, SMP_MAX, 127, 0, 0, 1);
		write_reg(CFG_UNUSED, 'hFFFF);
		fill_random(180);
		wait_drained();

		set_config(SMP_MAX, 0, 0, 255, 'hFFFF, 0);
		fill_random(180);
		wait_drained();

		set_config(512, 513, 45, 90, 12, 1);
		fill_random(180);
		wait_drained();

		set_config($urandom_range(0, 400), $urandom_range(500, SMP_MAX), $urandom_range(0, 90),
			$urandom_range(0, 180), $urandom_range(1, 20), $urandom_range(0, 1));
		fill_random(180);
		wait_drained();

		repeat (4) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			mismatches++;
		end
		$display("Run covered %0d ticks under %0d register settings.", ticks_taken, settings_used);
		$display("Commands finished: %0d, of which %0d reported a step timeout.", cmds_done,
			cmds_timed_out);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

[detent_servo_positioner_core.f]
src/dsp_pkg.sv
src/dsp_ctrl.sv
src/detent_servo_positioner_core.sv
bench/tb.sv
